@@ sv/rpps_pkg.sv @@
// shared types and constants for the reactive power projected step block
`default_nettype none

package rpps_pkg;

   // radicand width: rating^2 - real^2 stays below 2^62
   localparam int RAD_W      = 62;
   // one root bit per step, root below 2^31
   localparam int SQRT_STEPS = RAD_W / 2;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATING    = 1'd1;

   typedef struct packed {
      logic [9:0]         time_slot;
      logic [1:0]         phase;
      logic signed [31:0] old_real;
      logic signed [31:0] old_reactive;
      logic signed [31:0] gradient_reactive;
   } req_type;

   typedef struct packed {
      logic [9:0]         slot_out;
      logic [1:0]         phase_out;
      logic signed [31:0] new_reactive;
   } rsp_type;

   // products stage
   typedef struct packed {
      logic [9:0]         slot;
      logic [1:0]         phase;
      logic signed [31:0] old_reactive;
      logic signed [63:0] prod;
      logic [RAD_W-1:0]   s2;
      logic [RAD_W:0]     p2;
   } prod_stage_type;

   // square root stage, carries the saturated q along
   typedef struct packed {
      logic [9:0]         slot;
      logic [1:0]         phase;
      logic signed [31:0] q;
      logic [RAD_W-1:0]   x;
      logic [RAD_W-1:0]   res;
   } sqrt_stage_type;

endpackage

`default_nettype wire

@@ sv/reactive_power_projected_step_top.sv @@
// top level of the reactive power projected gradient step pipeline
// 34 register stages: products, step and radicand, 31 root stages, clamp
// throughput: one request per cycle while the result side does not stall, every stage is registered and none iterates
// each stage holds a valid bit and advances when empty or when its successor moves
// reset: synchronous, clears all valid bits and both csr registers to zero
`default_nettype none

module reactive_power_projected_step_top import rpps_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   // request channel
   input  wire                  req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // result channel
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output rsp_type              rsp_data,
   // csr write channel
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [31:0]           csr_wdata
);

   // csr registers
   logic [31:0] step_size_ff;
   logic [30:0] rating_ff;

   // pipeline registers
   prod_stage_type prod_ff, prod_in;
   logic           prod_v_ff;
   sqrt_stage_type sq_ff [0:SQRT_STEPS];
   sqrt_stage_type sq_in [0:SQRT_STEPS];
   logic           sq_v_ff [0:SQRT_STEPS];
   rsp_type        out_ff, out_in;
   logic           out_v_ff;

   // load enables, rippled back from the result side
   logic prod_go;
   logic sq_go [0:SQRT_STEPS];
   logic out_go;

   // stage 2 temporaries
   logic signed [47:0] step_w;
   logic signed [48:0] q_wide;

   // clamp temporaries
   logic signed [31:0] lim;
   logic signed [31:0] neg_lim;

   // products temporaries
   logic signed [63:0] prod_w;
   logic [31:0]        pa;
   logic [63:0]        p2_w;

   // csr port always ready; registers written when idle is up to the user, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= '0;
         rating_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STEP_SIZE: step_size_ff <= csr_wdata;
            CSR_RATING:    rating_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // flow control: a stage loads when empty or when its content moves on
   assign out_go = !out_v_ff || !rsp_stall;

   always_comb begin
      sq_go[SQRT_STEPS] = !sq_v_ff[SQRT_STEPS] || out_go;
      for (int k = SQRT_STEPS - 1; k >= 0; k--) begin
         sq_go[k] = !sq_v_ff[k] || sq_go[k + 1];
      end
   end

   assign prod_go   = !prod_v_ff || sq_go[0];
   assign req_stall = !prod_go;

   // stage 1: step product and the two squares, all exact
   // unsigned step times signed gradient stays below 2^63 in magnitude
   assign prod_w = $signed({32'd0, step_size_ff})
                   * $signed({{32{req_data.gradient_reactive[31]}},
                              req_data.gradient_reactive});
   assign pa     = req_data.old_real[31] ? (~req_data.old_real + 32'd1)
                                         : req_data.old_real;
   assign p2_w   = {32'd0, pa} * {32'd0, pa};

   always_comb begin
      prod_in.slot         = req_data.time_slot;
      prod_in.phase        = req_data.phase;
      prod_in.old_reactive = req_data.old_reactive;
      prod_in.prod         = prod_w;
      prod_in.s2           = {31'd0, rating_ff} * {31'd0, rating_ff};
      prod_in.p2           = p2_w[RAD_W:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else if (prod_go) begin
         prod_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_go) begin
         prod_ff <= prod_in;
      end
   end

   // stage 2: floor shift of the product, subtract, saturate, radicand
   // taking the upper bits of a two's complement word rounds toward minus infinity
   assign step_w = prod_ff.prod[63:16];
   assign q_wide = {{17{prod_ff.old_reactive[31]}}, prod_ff.old_reactive}
                   - {step_w[47], step_w};

   always_comb begin
      sq_in[0].slot  = prod_ff.slot;
      sq_in[0].phase = prod_ff.phase;
      if (q_wide[48:31] == '0 || q_wide[48:31] == '1) begin
         sq_in[0].q = q_wide[31:0];
      end else if (q_wide[48]) begin
         sq_in[0].q = 32'sh8000_0000;
      end else begin
         sq_in[0].q = 32'sh7fff_ffff;
      end
      // real power beyond the rating leaves no headroom
      if ({1'b0, prod_ff.s2} > prod_ff.p2) begin
         sq_in[0].x = prod_ff.s2 - prod_ff.p2[RAD_W-1:0];
      end else begin
         sq_in[0].x = '0;
      end
      sq_in[0].res = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (sq_go[0]) begin
         sq_v_ff[0] <= prod_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_go[0]) begin
         sq_ff[0] <= sq_in[0];
      end
   end

   // root stages: one result bit per stage, digit-by-digit floor square root
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      logic [RAD_W:0] trial;

      assign trial = {1'b0, sq_ff[k].res} + {1'b0, BIT};

      always_comb begin
         sq_in[k + 1].slot  = sq_ff[k].slot;
         sq_in[k + 1].phase = sq_ff[k].phase;
         sq_in[k + 1].q     = sq_ff[k].q;
         if ({1'b0, sq_ff[k].x} >= trial) begin
            sq_in[k + 1].x   = sq_ff[k].x - trial[RAD_W-1:0];
            sq_in[k + 1].res = (sq_ff[k].res >> 1) + BIT;
         end else begin
            sq_in[k + 1].x   = sq_ff[k].x;
            sq_in[k + 1].res = sq_ff[k].res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k + 1] <= 1'b0;
         end else if (sq_go[k + 1]) begin
            sq_v_ff[k + 1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (sq_go[k + 1]) begin
            sq_ff[k + 1] <= sq_in[k + 1];
         end
      end
   end

   // final stage: clamp q into the band of +-root
   assign lim     = {1'b0, sq_ff[SQRT_STEPS].res[30:0]};
   assign neg_lim = -lim;

   always_comb begin
      out_in.slot_out  = sq_ff[SQRT_STEPS].slot;
      out_in.phase_out = sq_ff[SQRT_STEPS].phase;
      if (sq_ff[SQRT_STEPS].q > lim) begin
         out_in.new_reactive = lim;
      end else if (sq_ff[SQRT_STEPS].q < neg_lim) begin
         out_in.new_reactive = neg_lim;
      end else begin
         out_in.new_reactive = sq_ff[SQRT_STEPS].q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_go) begin
         out_v_ff <= sq_v_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_go) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // the clamp band is symmetric, so the most negative code never leaves
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.new_reactive != 32'sh8000_0000)
      else $error("clamped result hit the most negative code");

   // the root of a 62-bit radicand fits in 31 bits
   a_root_width: assert property (@(posedge clock) disable iff (reset)
      sq_v_ff[SQRT_STEPS] |-> sq_ff[SQRT_STEPS].res[RAD_W-1:31] == '0)
      else $error("square root result wider than 31 bits");

   // no headroom when the real power reaches the rating
   a_no_headroom: assert property (@(posedge clock) disable iff (reset)
      (prod_v_ff && sq_go[0] && ({1'b0, prod_ff.s2} <= prod_ff.p2))
      |=> sq_ff[0].x == '0)
      else $error("radicand not zero with real power beyond rating");

   // a stalled result stage blocks the last root stage only when that stage is full
   a_ripple_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && sq_v_ff[SQRT_STEPS]) |-> !sq_go[SQRT_STEPS])
      else $error("last root stage advanced into a stalled result");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// testbench for the reactive power projected gradient step pipeline
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rpps_pkg::*;

   // request to result latency of the pipeline
   localparam int PIPE_LATENCY = 34;
   // q range after the step, before the headroom clamp
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   // clock and reset, every input known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_STEP_SIZE;
   logic [31:0]          csr_wdata = '0;

   // local copy of the csr registers, updated when a write lands
   logic [31:0] step_shadow   = '0;
   logic [30:0] rating_shadow = '0;

   // projected results waiting for the block to deliver them, oldest first
   rsp_type expected_projections[$];

   // idling knobs, percent chance of a burst per request or per cycle
   int gap_pct   = 0;
   int stall_pct = 0;

   int n_fail     = 0;
   int n_requests = 0;
   int n_results  = 0;
   int n_settings = 0;

   always #4 clock = ~clock;

   reactive_power_projected_step_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // floor square root, one root bit decided per pass from the top down
   function automatic logic [31:0] floor_root(logic [63:0] radicand);
      logic [31:0] root;
      logic [31:0] trial;
      logic [63:0] trial_sq;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial    = root | (32'd1 << b);
         trial_sq = {32'd0, trial} * {32'd0, trial};
         if (trial_sq <= radicand) root = trial;
      end
      return root;
   endfunction

   // step against the gradient, saturate, then clamp to the reactive headroom
   function automatic rsp_type project_reactive(logic [31:0] step, logic [30:0] rating,
                                                req_type r);
      longint      prod;
      longint      q;
      longint      lim;
      longint      real_mag;
      logic [63:0] rating_sq;
      logic [63:0] real_sq;
      rsp_type     o;
      // exact Q32.32 product, arithmetic shift floors toward minus infinity
      prod = longint'({32'd0, step}) * longint'($signed(r.gradient_reactive));
      q    = longint'($signed(r.old_reactive)) - (prod >>> 16);
      if (q > Q_MAX) q = Q_MAX;
      else if (q < Q_MIN) q = Q_MIN;
      // headroom left by the real power, zero when real power exceeds the rating
      real_mag = longint'($signed(r.old_real));
      if (real_mag < 0) real_mag = -real_mag;
      rating_sq = {33'd0, rating} * {33'd0, rating};
      real_sq   = 64'(real_mag) * 64'(real_mag);
      lim = (rating_sq > real_sq) ? longint'({32'd0, floor_root(rating_sq - real_sq)}) : 0;
      if (q > lim) q = lim;
      else if (q < -lim) q = -lim;
      o.slot_out     = r.time_slot;
      o.phase_out    = r.phase;
      o.new_reactive = q[31:0];
      return o;
   endfunction

   // Q16.16 from a whole number
   function automatic logic [31:0] fx(int whole);
      return 32'(whole * 65536);
   endfunction

   function automatic req_type mk_req(int slot, int phase, logic [31:0] p,
                                      logic [31:0] q, logic [31:0] g);
      req_type r;
      r.time_slot         = 10'(slot);
      r.phase             = 2'(phase);
      r.old_real          = p;
      r.old_reactive      = q;
      r.gradient_reactive = g;
      return r;
   endfunction

   // one signed word: full random, small, an extreme, or inside +-span
   function automatic logic [31:0] pick_word(logic [30:0] span);
      logic [31:0] v;
      logic        may_flip;
      may_flip = 1'b0;
      case ($urandom_range(5))
         0, 1: v = $urandom();
         2: begin
            v = $urandom_range(32'h0003_FFFF);
            may_flip = 1'b1;
         end
         3: begin
            case ($urandom_range(4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0001;
            endcase
         end
         default: begin
            v = $urandom_range(32'(span));
            may_flip = 1'b1;
         end
      endcase
      if (may_flip && $urandom_range(1) == 1) v = -v;
      return v;
   endfunction

   // random request scaled around the current rating so the clamp is reached often
   function automatic req_type random_request();
      return mk_req($urandom_range(1023), $urandom_range(3), pick_word(rating_shadow),
                    pick_word(rating_shadow), pick_word(rating_shadow));
   endfunction

   // send one request, optionally after an idle burst, and record its projection
   task automatic send_request(input req_type item);
      int n;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         n = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      // valid stays high between back to back requests
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_projections.push_back(project_reactive(step_shadow, rating_shadow, item));
      n_requests++;
   endtask

   // stop sending and wait until every projected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_projections.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one csr write, valid left high so a following write needs no second assignment
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_STEP_SIZE) step_shadow = value;
      else rating_shadow = value[30:0];
   endtask

   // both registers, only called with the pipeline empty
   task automatic set_config(input logic [31:0] step, input logic [31:0] rating_word);
      write_csr(CSR_STEP_SIZE, step);
      write_csr(CSR_RATING, rating_word);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // registers at reset are zero, so every result must come back as zero
   task automatic test_reset_values();
      gap_pct   = 20;
      stall_pct = 20;
      send_request(mk_req(0, 0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_request(mk_req(1023, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      repeat (2) send_request(random_request());
      drain();
   endtask

   // hand picked cases: clamp both ways, no headroom, saturation, floor rounding
   task automatic test_directed_cases();
      gap_pct   = 20;
      stall_pct = 20;
      // step 1.0, rating 100.0
      set_config(32'h0001_0000, fx(100));
      send_request(mk_req(0, 0, 32'd0, 32'd0, 32'd0));
      send_request(mk_req(1, 1, fx(60), fx(10), -fx(5)));      // inside the band
      send_request(mk_req(2, 2, fx(60), 32'd0, -fx(1000)));    // clamp to +headroom
      send_request(mk_req(3, 0, -fx(60), 32'd0, fx(1000)));    // clamp to -headroom
      send_request(mk_req(4, 1, fx(100), fx(3), 32'd0));       // real power equals rating
      send_request(mk_req(5, 2, -fx(150), fx(3), 32'd0));      // real power beyond rating
      send_request(mk_req(6, 0, 32'h8000_0000, fx(3), 32'd0)); // most negative real power
      send_request(mk_req(7, 1, 32'h7FFF_FFFF, -fx(3), 32'd0));
      send_request(mk_req(1023, 3, 32'd0, fx(20), fx(5)));     // phase 3, top slot
      send_request(mk_req(512, 3, fx(99), 32'h8000_0000, 32'd0));
      drain();
      // largest step and rating: the saturation shows through the clamp
      set_config(32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_request(mk_req(8, 0, 32'd0, 32'd0, 32'h8000_0000));
      send_request(mk_req(9, 1, 32'd0, 32'd0, 32'h7FFF_FFFF));
      send_request(mk_req(10, 2, 32'd0, 32'h8000_0000, 32'd0));
      send_request(mk_req(11, 0, 32'd0, 32'h7FFF_FFFF, 32'd0));
      send_request(mk_req(12, 1, 32'd0, 32'd0, 32'hFFFF_FFFF)); // negative product floors
      send_request(mk_req(13, 2, 32'd0, 32'd0, 32'h0000_0001));
      drain();
      // step 0.5, rating 1.0: fractional products round toward minus infinity
      set_config(32'h0000_8000, fx(1));
      send_request(mk_req(14, 0, 32'd0, 32'd0, 32'hFFFF_FFFF));
      send_request(mk_req(15, 1, 32'd0, 32'd0, 32'h0000_0001));
      send_request(mk_req(16, 2, 32'd0, 32'd0, 32'hFFFF_FFFD));
      drain();
   endtask

   // several settings including the extremes, random requests under idling
   task automatic test_random_settings();
      logic [31:0] step_v;
      logic [31:0] rating_v;
      for (int k = 0; k < 7; k++) begin
         case (k)
            0: begin step_v = 32'd0;        rating_v = 32'h7FFF_FFFF; end
            1: begin step_v = 32'hFFFF_FFFF; rating_v = 32'h7FFF_FFFF; end
            2: begin step_v = 32'hFFFF_FFFF; rating_v = 32'd0;         end
            3: begin
               step_v   = $urandom_range(32'h0004_0000);
               rating_v = $urandom_range(32'h00FF_FFFF);
            end
            default: begin
               step_v   = ($urandom_range(1) == 1) ? $urandom() : $urandom_range(32'h0002_0000);
               rating_v = $urandom();   // top bit is outside the register and ignored
            end
         endcase
         // some phases idle only on one side
         gap_pct   = (k == 4) ? 0 : 25;
         stall_pct = (k == 5) ? 0 : 25;
         set_config(step_v, rating_v);
         repeat (85) send_request(random_request());
         drain();
      end
   endtask

   // back to back requests with the result side never stalled
   task automatic test_full_rate();
      gap_pct   = 0;
      stall_pct = 0;
      set_config($urandom_range(32'h0002_0000), $urandom_range(32'h0FFF_FFFF));
      repeat (100) send_request(random_request());
      drain();
   endtask

   // result side stall in random bursts while stall_pct is nonzero
   initial begin : result_backpressure
      int n;
      forever begin
         @(posedge clock);
         if (!reset && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            n = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // compare each delivered result with the oldest projection
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_projections.size() == 0) begin
            $error("unexpected result: slot %0d phase %0d new_reactive %0d",
                   rsp_data.slot_out, rsp_data.phase_out, rsp_data.new_reactive);
            n_fail++;
         end else begin
            want = expected_projections.pop_front();
            n_results++;
            if (rsp_data.slot_out !== want.slot_out) begin
               $error("slot_out: expected %0d, got %0d", want.slot_out, rsp_data.slot_out);
               n_fail++;
            end
            if (rsp_data.phase_out !== want.phase_out) begin
               $error("phase_out: expected %0d, got %0d", want.phase_out, rsp_data.phase_out);
               n_fail++;
            end
            if (rsp_data.new_reactive !== want.new_reactive) begin
               $error("new_reactive: expected %0d, got %0d",
                      want.new_reactive, rsp_data.new_reactive);
               n_fail++;
            end
         end
      end
   end

   // main sequence: reset once, then each test in turn
   initial begin : run_tests
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_cases();
      test_random_settings();
      test_full_rate();
      // catch any stray result trailing behind the last one
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      $display("run covered %0d requests over %0d csr settings, %0d results checked",
               n_requests, n_settings, n_results);
      if (n_fail == 0) begin
         $display("PASS reactive_power_projected_step_top");
      end else begin
         $display("FAIL reactive_power_projected_step_top");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("FAIL reactive_power_projected_step_top");
      $finish;
   end

endmodule

`default_nettype wire
